>>> src/lj_pkg.sv
// Shared types, constants and helpers for the Lennard-Jones pair force engine.
package lj_pkg;

    localparam int MAX_ATOMS   = 1024;
    localparam int ADDR_W      = $clog2(MAX_ATOMS);
    localparam int IDX_EXT_W   = 17;
    localparam int DIV_TOP_BIT = 56;

    typedef logic signed [47:0] t_q;

    localparam t_q Q_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam t_q Q_MIN  = 48'sh8000_0000_0000;
    localparam t_q Q_HALF = 48'sd8388608;
    localparam t_q Q_ONE  = 48'sd16777216;
    localparam t_q Q_C48  = 48'sd805306368;
    localparam t_q Q_C4   = 48'sd67108864;

    localparam logic [31:0] CUTOFF_RST = 32'd409600;
    localparam logic [23:0] WELL_RST   = 24'd65536;
    localparam logic [23:0] SIGMA_RST  = 24'd65536;

    typedef struct packed {
        t_q x;
        t_q y;
        t_q z;
    } t_vec3;

    typedef struct packed {
        t_q   val;
        logic ovf;
    } t_qres;

    typedef struct packed {
        logic start;
        t_q   a;
        t_q   b;
    } t_mul_req;

    typedef struct packed {
        logic done;
        t_q   val;
        logic ovf;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [49:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_q   val;
        logic ovf;
    } t_div_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_vec3             wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [1:0] {
        ACT_PAIR,
        ACT_READ_ATOM,
        ACT_READ_TOTALS,
        ACT_NONE
    } t_action;

    typedef enum logic [1:0] {
        REG_CUTOFF,
        REG_WELL,
        REG_SIGMA,
        REG_NONE
    } t_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DELTA,
        ST_SQUARE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_RD_I,
        ST_WR_I,
        ST_RD_J,
        ST_WR_J,
        ST_ATOM_RD,
        ST_ATOM_WR,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        STEP_SR4,
        STEP_SR6_RAW,
        STEP_SR6,
        STEP_F_POLY,
        STEP_F_SR2,
        STEP_F_EPS,
        STEP_FORCE,
        STEP_E_POLY,
        STEP_E_EPS,
        STEP_ENERGY,
        STEP_VIRIAL,
        STEP_FX,
        STEP_FY,
        STEP_FZ
    } t_step;

    // Clamps a 49-bit sum back into the 48-bit range.
    function automatic t_qres sat_sum(input logic [48:0] s);
        t_qres r;
        r.ovf = s[48] ^ s[47];
        if (!r.ovf) begin
            r.val = s[47:0];
        end else if (s[48]) begin
            r.val = Q_MIN;
        end else begin
            r.val = Q_MAX;
        end
        return r;
    endfunction

endpackage

>>> src/lj_qmul.sv
// Multi-cycle saturating Q24.24 multiplier built on one shared 24x24 multiplier.
module lj_qmul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lj_pkg::t_mul_req i_req,
    output lj_pkg::t_mul_rsp o_rsp
);

    logic [2:0]  r_step;
    logic        r_done;
    logic [47:0] r_ua;
    logic [47:0] r_ub;
    logic        r_neg;
    logic [47:0] r_p;
    logic [47:0] r_hh;
    logic [49:0] r_acc;
    lj_pkg::t_q  r_val;
    logic        r_ovf;

    logic [23:0] op_x;
    logic [23:0] op_y;
    logic [47:0] prod;
    logic [50:0] m;
    logic [50:0] lim;
    logic        fin_ovf;
    lj_pkg::t_q  fin_val;

    always_comb begin
        case (r_step)
            3'd1: begin
                op_x = r_ua[47:24];
                op_y = r_ub[47:24];
            end
            3'd2: begin
                op_x = r_ua[47:24];
                op_y = r_ub[23:0];
            end
            3'd3: begin
                op_x = r_ua[23:0];
                op_y = r_ub[47:24];
            end
            3'd4: begin
                op_x = r_ua[23:0];
                op_y = r_ub[23:0];
            end
            default: begin
                op_x = 24'd0;
                op_y = 24'd0;
            end
        endcase
        prod = op_x * op_y;
        m    = {4'd0, r_hh[22:0], 24'd0} + {1'b0, r_acc};
        lim  = r_neg ? 51'h0_8000_0000_0000 : 51'h0_7FFF_FFFF_FFFF;
        // A high partial product of 2^23 or more already exceeds the range.
        fin_ovf = (|r_hh[47:23]) || (m > lim);
        if (fin_ovf) begin
            fin_val = r_neg ? lj_pkg::Q_MIN : lj_pkg::Q_MAX;
        end else begin
            fin_val = r_neg ? -m[47:0] : m[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == 3'd6);
            if (i_req.start) begin
                r_step <= 3'd1;
            end else if (r_step != 3'd0) begin
                r_step <= (r_step == 3'd6) ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ua  <= i_req.a[47] ? 48'(-i_req.a) : i_req.a;
            r_ub  <= i_req.b[47] ? 48'(-i_req.b) : i_req.b;
            r_neg <= i_req.a[47] ^ i_req.b[47];
        end
        if (r_step >= 3'd1 && r_step <= 3'd4) begin
            r_p <= prod;
        end
        case (r_step)
            3'd2: r_hh <= r_p;
            3'd3: r_acc <= {2'd0, r_p};
            3'd4: r_acc <= r_acc + {2'd0, r_p};
            3'd5: r_acc <= r_acc + {26'd0, r_p[47:24]};
            3'd6: begin
                r_val <= fin_val;
                r_ovf <= fin_ovf;
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.val  = r_val;
    assign o_rsp.ovf  = r_ovf;

endmodule

>>> src/lj_div.sv
// Restoring divider that forms floor(2^56 / rsq) one quotient bit per cycle.
module lj_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lj_pkg::t_div_req i_req,
    output lj_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [49:0] r_div;
    logic [50:0] r_rem;
    logic [56:0] r_q;

    logic [50:0] rem_sh;
    logic        ge;
    logic [50:0] n_rem;
    logic [56:0] n_q;

    always_comb begin
        // The dividend is a single one at the top bit.
        rem_sh = {r_rem[49:0], (r_cnt == 6'(lj_pkg::DIV_TOP_BIT))};
        ge     = rem_sh >= {1'b0, r_div};
        n_rem  = ge ? rem_sh - {1'b0, r_div} : rem_sh;
        n_q    = {r_q[55:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_cnt <= 6'(lj_pkg::DIV_TOP_BIT);
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = |r_q[56:47];
    assign o_rsp.val  = o_rsp.ovf ? lj_pkg::Q_MAX : {1'b0, r_q[46:0]};

endmodule

>>> src/lj_store.sv
// Per-atom force memory: one write port, one registered read port.
module lj_store (
    input  logic             i_clk,
    input  lj_pkg::t_mem_req i_req,
    output lj_pkg::t_vec3    o_rdata
);

    lj_pkg::t_vec3 r_mem [lj_pkg::MAX_ATOMS];
    lj_pkg::t_vec3 r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lennard_jones_pair_force_engine_top.sv
// Top level of the Lennard-Jones pair force engine: control, config and output register.
//
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_stall   action, atoms, two positions
//  out       output     o_out_valid / i_out_stall forces, energy, virial, flags
//  config    input      APB psel/penable/pwrite   cutoff, well depth, sigma^6
//
// A pair inside the cutoff spends most of its time in the 57-step divider
// and in fourteen passes through the shared multiplier. Pairs outside the
// cutoff go to the result after the distance check, and read transactions
// skip the arithmetic. After reset all 1024 entries of the force memory are
// cleared, one entry a cycle, with o_in_stall high. A stalled result sits in
// the output register while the next transaction is accepted and worked on.
module lennard_jones_pair_force_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [9:0]         i_first_atom,
    input  logic [9:0]         i_second_atom,
    input  logic signed [31:0] i_first_pos_x,
    input  logic signed [31:0] i_first_pos_y,
    input  logic signed [31:0] i_first_pos_z,
    input  logic signed [31:0] i_second_pos_x,
    input  logic signed [31:0] i_second_pos_y,
    input  logic signed [31:0] i_second_pos_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_out_force_x,
    output logic signed [47:0] o_out_force_y,
    output logic signed [47:0] o_out_force_z,
    output logic signed [47:0] o_out_energy,
    output logic signed [47:0] o_out_virial,
    output logic               o_within_cutoff,
    output logic               o_overflow_flag
);

    localparam int AW = lj_pkg::ADDR_W;
    localparam int XW = lj_pkg::IDX_EXT_W;

    lj_pkg::t_state   r_state;
    lj_pkg::t_state   n_state;

    logic [31:0]      r_cutoff;
    logic [23:0]      r_well;
    logic [23:0]      r_sigma;

    logic [AW-1:0]    r_clr;
    logic [1:0]       r_sq_cnt;
    lj_pkg::t_step    r_prg;
    logic             r_mul_wait;
    lj_pkg::t_q       r_etot;
    lj_pkg::t_q       r_vtot;

    lj_pkg::t_action  r_act;
    logic [9:0]       r_ia;
    logic [9:0]       r_ja;
    logic signed [31:0] r_pi [3];
    logic signed [31:0] r_pj [3];
    logic signed [32:0] r_d [3];
    logic [47:0]      r_prod;
    logic [49:0]      r_rsq;
    lj_pkg::t_q       r_sr2;
    lj_pkg::t_q       r_sr6;
    lj_pkg::t_q       r_t;
    lj_pkg::t_q       r_force;

    lj_pkg::t_vec3    r_res_f;
    lj_pkg::t_q       r_res_e;
    lj_pkg::t_q       r_res_v;
    logic             r_res_w;
    logic             r_res_o;

    logic             r_ov;
    lj_pkg::t_vec3    r_o_f;
    lj_pkg::t_q       r_o_e;
    lj_pkg::t_q       r_o_v;
    logic             r_o_w;
    logic             r_o_o;

    lj_pkg::t_mem_req mem_req;
    lj_pkg::t_vec3    mem_rdata;
    lj_pkg::t_mul_req mul_req;
    lj_pkg::t_mul_rsp mul_rsp;
    lj_pkg::t_div_req div_req;
    lj_pkg::t_div_rsp div_rsp;

    logic             in_acc;
    logic             out_take;
    logic             out_load;
    logic             cfg_wr;
    logic [XW-1:0]    in_ia_ext;
    logic [XW-1:0]    ia_ext;
    logic [XW-1:0]    ja_ext;
    logic             ia_ok;
    logic             ja_ok;
    logic [AW-1:0]    ia_addr;
    logic [AW-1:0]    ja_addr;
    logic [32:0]      mag [3];
    logic             far_any;
    logic [23:0]      sq_mag;
    logic [47:0]      sq_prod;
    logic             pair_go;
    lj_pkg::t_qres    s_half;
    lj_pkg::t_qres    s_one;
    lj_pkg::t_q       mul_a;
    lj_pkg::t_q       mul_b;
    lj_pkg::t_q       dsc [3];
    lj_pkg::t_qres    ui_x, ui_y, ui_z;
    lj_pkg::t_qres    uj_x, uj_y, uj_z;
    lj_pkg::t_qres    e_sum;
    lj_pkg::t_qres    v_sum;

    lj_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    lj_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    lj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= lj_pkg::CUTOFF_RST;
            r_well   <= lj_pkg::WELL_RST;
            r_sigma  <= lj_pkg::SIGMA_RST;
        end else if (cfg_wr) begin
            case (lj_pkg::t_reg'(paddr[3:2]))
                lj_pkg::REG_CUTOFF: r_cutoff <= pwdata;
                lj_pkg::REG_WELL:   r_well   <= pwdata[23:0];
                lj_pkg::REG_SIGMA:  r_sigma  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (lj_pkg::t_reg'(paddr[3:2]))
            lj_pkg::REG_CUTOFF: prdata = r_cutoff;
            lj_pkg::REG_WELL:   prdata = {8'd0, r_well};
            lj_pkg::REG_SIGMA:  prdata = {8'd0, r_sigma};
            default:            prdata = 32'd0;
        endcase
    end

    // Datapath helpers.
    assign o_in_stall = (r_state != lj_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_ov && !i_out_stall;
    assign out_load   = (r_state == lj_pkg::ST_FINISH) && (!r_ov || !i_out_stall);

    assign in_ia_ext = XW'(i_first_atom);
    assign ia_ext    = XW'(r_ia);
    assign ja_ext    = XW'(r_ja);
    assign ia_ok     = ia_ext < XW'(lj_pkg::MAX_ATOMS);
    assign ja_ok     = ja_ext < XW'(lj_pkg::MAX_ATOMS);
    assign ia_addr   = ia_ext[AW-1:0];
    assign ja_addr   = ja_ext[AW-1:0];

    always_comb begin
        far_any = 1'b0;
        for (int k = 0; k < 3; k++) begin
            mag[k]  = r_d[k][32] ? 33'(-r_d[k]) : r_d[k];
            far_any = far_any | (|mag[k][32:24]);
            dsc[k]  = {{7{r_d[k][32]}}, r_d[k], 8'd0};
        end
        case (r_sq_cnt)
            2'd0:    sq_mag = mag[0][23:0];
            2'd1:    sq_mag = mag[1][23:0];
            2'd2:    sq_mag = mag[2][23:0];
            default: sq_mag = 24'd0;
        endcase
        sq_prod = sq_mag * sq_mag;
        pair_go = (r_act == lj_pkg::ACT_PAIR) && ia_ok && ja_ok && !far_any
                  && (r_rsq < {2'd0, r_cutoff, 16'd0});
    end

    // Multiplier program: operands for each step of the force, energy and virial chain.
    always_comb begin
        s_half = lj_pkg::sat_sum({r_sr6[47], r_sr6} - {lj_pkg::Q_HALF[47], lj_pkg::Q_HALF});
        s_one  = lj_pkg::sat_sum({r_sr6[47], r_sr6} - {lj_pkg::Q_ONE[47], lj_pkg::Q_ONE});
        case (r_prg)
            lj_pkg::STEP_SR4: begin
                mul_a = r_sr2;
                mul_b = r_sr2;
            end
            lj_pkg::STEP_SR6_RAW: begin
                mul_a = r_t;
                mul_b = r_sr2;
            end
            lj_pkg::STEP_SR6: begin
                mul_a = r_t;
                mul_b = {16'd0, r_sigma, 8'd0};
            end
            lj_pkg::STEP_F_POLY: begin
                mul_a = r_sr6;
                mul_b = s_half.val;
            end
            lj_pkg::STEP_F_SR2: begin
                mul_a = r_t;
                mul_b = r_sr2;
            end
            lj_pkg::STEP_F_EPS: begin
                mul_a = r_t;
                mul_b = {16'd0, r_well, 8'd0};
            end
            lj_pkg::STEP_FORCE: begin
                mul_a = r_t;
                mul_b = lj_pkg::Q_C48;
            end
            lj_pkg::STEP_E_POLY: begin
                mul_a = r_sr6;
                mul_b = s_one.val;
            end
            lj_pkg::STEP_E_EPS: begin
                mul_a = r_t;
                mul_b = {16'd0, r_well, 8'd0};
            end
            lj_pkg::STEP_ENERGY: begin
                mul_a = r_t;
                mul_b = lj_pkg::Q_C4;
            end
            lj_pkg::STEP_VIRIAL: begin
                mul_a = {6'd0, r_rsq[49:8]};
                mul_b = r_force;
            end
            lj_pkg::STEP_FX: begin
                mul_a = dsc[0];
                mul_b = r_force;
            end
            lj_pkg::STEP_FY: begin
                mul_a = dsc[1];
                mul_b = r_force;
            end
            lj_pkg::STEP_FZ: begin
                mul_a = dsc[2];
                mul_b = r_force;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Read-modify-write sums for the memory and the totals.
    always_comb begin
        ui_x  = lj_pkg::sat_sum({mem_rdata.x[47], mem_rdata.x} + {r_res_f.x[47], r_res_f.x});
        ui_y  = lj_pkg::sat_sum({mem_rdata.y[47], mem_rdata.y} + {r_res_f.y[47], r_res_f.y});
        ui_z  = lj_pkg::sat_sum({mem_rdata.z[47], mem_rdata.z} + {r_res_f.z[47], r_res_f.z});
        uj_x  = lj_pkg::sat_sum({mem_rdata.x[47], mem_rdata.x} - {r_res_f.x[47], r_res_f.x});
        uj_y  = lj_pkg::sat_sum({mem_rdata.y[47], mem_rdata.y} - {r_res_f.y[47], r_res_f.y});
        uj_z  = lj_pkg::sat_sum({mem_rdata.z[47], mem_rdata.z} - {r_res_f.z[47], r_res_f.z});
        e_sum = lj_pkg::sat_sum({r_etot[47], r_etot} + {r_res_e[47], r_res_e});
        v_sum = lj_pkg::sat_sum({r_vtot[47], r_vtot} + {r_res_v[47], r_res_v});
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lj_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes.
    always_comb begin
        n_state             = r_state;
        mem_req.we          = 1'b0;
        mem_req.waddr       = ia_addr;
        mem_req.wdata       = '0;
        mem_req.raddr       = ia_addr;
        mul_req.start       = 1'b0;
        mul_req.a           = mul_a;
        mul_req.b           = mul_b;
        div_req.start       = 1'b0;
        div_req.divisor     = r_rsq;
        case (r_state)
            lj_pkg::ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr;
                if (r_clr == AW'(lj_pkg::MAX_ATOMS - 1)) begin
                    n_state = lj_pkg::ST_IDLE;
                end
            end
            lj_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (lj_pkg::t_action'(i_action))
                        lj_pkg::ACT_PAIR: n_state = lj_pkg::ST_DELTA;
                        lj_pkg::ACT_READ_ATOM: begin
                            if (in_ia_ext < XW'(lj_pkg::MAX_ATOMS)) begin
                                n_state = lj_pkg::ST_ATOM_RD;
                            end else begin
                                n_state = lj_pkg::ST_FINISH;
                            end
                        end
                        default: n_state = lj_pkg::ST_FINISH;
                    endcase
                end
            end
            lj_pkg::ST_DELTA: n_state = lj_pkg::ST_SQUARE;
            lj_pkg::ST_SQUARE: begin
                if (r_sq_cnt == 2'd3) begin
                    n_state = lj_pkg::ST_CHECK;
                end
            end
            lj_pkg::ST_CHECK: begin
                if (pair_go && r_rsq != 50'd0) begin
                    div_req.start = 1'b1;
                    n_state       = lj_pkg::ST_DIV;
                end else begin
                    n_state = lj_pkg::ST_FINISH;
                end
            end
            lj_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = lj_pkg::ST_MUL;
                end
            end
            lj_pkg::ST_MUL: begin
                if (!r_mul_wait) begin
                    mul_req.start = 1'b1;
                end else if (mul_rsp.done && r_prg == lj_pkg::STEP_FZ) begin
                    n_state = lj_pkg::ST_RD_I;
                end
            end
            lj_pkg::ST_RD_I: n_state = lj_pkg::ST_WR_I;
            lj_pkg::ST_WR_I: begin
                mem_req.we       = 1'b1;
                mem_req.wdata.x  = ui_x.val;
                mem_req.wdata.y  = ui_y.val;
                mem_req.wdata.z  = ui_z.val;
                n_state          = lj_pkg::ST_RD_J;
            end
            lj_pkg::ST_RD_J: begin
                // Atom i was written the cycle before, so the same atom reads back updated.
                mem_req.raddr = ja_addr;
                n_state       = lj_pkg::ST_WR_J;
            end
            lj_pkg::ST_WR_J: begin
                mem_req.we       = 1'b1;
                mem_req.waddr    = ja_addr;
                mem_req.wdata.x  = uj_x.val;
                mem_req.wdata.y  = uj_y.val;
                mem_req.wdata.z  = uj_z.val;
                n_state          = lj_pkg::ST_FINISH;
            end
            lj_pkg::ST_ATOM_RD: n_state = lj_pkg::ST_ATOM_WR;
            lj_pkg::ST_ATOM_WR: begin
                mem_req.we = 1'b1;
                n_state    = lj_pkg::ST_FINISH;
            end
            lj_pkg::ST_FINISH: begin
                if (out_load) begin
                    n_state = lj_pkg::ST_IDLE;
                end
            end
            default: n_state = lj_pkg::ST_IDLE;
        endcase
    end

    // Control registers and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_sq_cnt   <= 2'd0;
            r_prg      <= lj_pkg::STEP_SR4;
            r_mul_wait <= 1'b0;
            r_etot     <= '0;
            r_vtot     <= '0;
            r_ov       <= 1'b0;
        end else begin
            case (r_state)
                lj_pkg::ST_CLEAR: r_clr <= r_clr + AW'(1);
                lj_pkg::ST_IDLE: begin
                    if (in_acc && lj_pkg::t_action'(i_action) == lj_pkg::ACT_READ_TOTALS) begin
                        r_etot <= '0;
                        r_vtot <= '0;
                    end
                end
                lj_pkg::ST_DELTA:  r_sq_cnt <= 2'd0;
                lj_pkg::ST_SQUARE: r_sq_cnt <= r_sq_cnt + 2'd1;
                lj_pkg::ST_DIV:    r_prg <= lj_pkg::STEP_SR4;
                lj_pkg::ST_MUL: begin
                    if (!r_mul_wait) begin
                        r_mul_wait <= 1'b1;
                    end else if (mul_rsp.done) begin
                        r_mul_wait <= 1'b0;
                        r_prg      <= lj_pkg::t_step'(r_prg + 4'd1);
                    end
                end
                lj_pkg::ST_WR_J: begin
                    r_etot <= e_sum.val;
                    r_vtot <= v_sum.val;
                end
                default: ;
            endcase
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            lj_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_act   <= lj_pkg::t_action'(i_action);
                    r_ia    <= i_first_atom;
                    r_ja    <= i_second_atom;
                    r_pi[0] <= i_first_pos_x;
                    r_pi[1] <= i_first_pos_y;
                    r_pi[2] <= i_first_pos_z;
                    r_pj[0] <= i_second_pos_x;
                    r_pj[1] <= i_second_pos_y;
                    r_pj[2] <= i_second_pos_z;
                    r_res_f <= '0;
                    r_res_w <= 1'b0;
                    r_res_o <= 1'b0;
                    if (lj_pkg::t_action'(i_action) == lj_pkg::ACT_READ_TOTALS) begin
                        r_res_e <= r_etot;
                        r_res_v <= r_vtot;
                    end else begin
                        r_res_e <= '0;
                        r_res_v <= '0;
                    end
                end
            end
            lj_pkg::ST_DELTA: begin
                for (int k = 0; k < 3; k++) begin
                    r_d[k] <= {r_pi[k][31], r_pi[k]} - {r_pj[k][31], r_pj[k]};
                end
                r_rsq <= '0;
            end
            lj_pkg::ST_SQUARE: begin
                r_prod <= sq_prod;
                if (r_sq_cnt != 2'd0) begin
                    r_rsq <= r_rsq + {2'd0, r_prod};
                end
            end
            lj_pkg::ST_CHECK: begin
                // Zero distance inside the cutoff only raises the flag.
                if (pair_go && r_rsq == 50'd0) begin
                    r_res_o <= 1'b1;
                end
            end
            lj_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    r_sr2   <= div_rsp.val;
                    r_res_o <= r_res_o | div_rsp.ovf;
                end
            end
            lj_pkg::ST_MUL: begin
                if (r_mul_wait && mul_rsp.done) begin
                    r_res_o <= r_res_o | mul_rsp.ovf
                               | ((r_prg == lj_pkg::STEP_F_POLY) & s_half.ovf)
                               | ((r_prg == lj_pkg::STEP_E_POLY) & s_one.ovf);
                    case (r_prg)
                        lj_pkg::STEP_SR6:    r_sr6     <= mul_rsp.val;
                        lj_pkg::STEP_FORCE:  r_force   <= mul_rsp.val;
                        lj_pkg::STEP_ENERGY: r_res_e   <= mul_rsp.val;
                        lj_pkg::STEP_VIRIAL: r_res_v   <= mul_rsp.val;
                        lj_pkg::STEP_FX:     r_res_f.x <= mul_rsp.val;
                        lj_pkg::STEP_FY:     r_res_f.y <= mul_rsp.val;
                        lj_pkg::STEP_FZ:     r_res_f.z <= mul_rsp.val;
                        default:             r_t       <= mul_rsp.val;
                    endcase
                end
            end
            lj_pkg::ST_WR_I: r_res_o <= r_res_o | ui_x.ovf | ui_y.ovf | ui_z.ovf;
            lj_pkg::ST_WR_J: begin
                r_res_o <= r_res_o | uj_x.ovf | uj_y.ovf | uj_z.ovf | e_sum.ovf | v_sum.ovf;
                r_res_w <= 1'b1;
            end
            lj_pkg::ST_ATOM_WR: r_res_f <= mem_rdata;
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_f <= r_res_f;
            r_o_e <= r_res_e;
            r_o_v <= r_res_v;
            r_o_w <= r_res_w;
            r_o_o <= r_res_o;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_out_force_x   = r_o_f.x;
    assign o_out_force_y   = r_o_f.y;
    assign o_out_force_z   = r_o_f.z;
    assign o_out_energy    = r_o_e;
    assign o_out_virial    = r_o_v;
    assign o_within_cutoff = r_o_w;
    assign o_overflow_flag = r_o_o;

endmodule

>>> src/lj_chk.sv
// Port-level assertions for the pair force engine, bound to the top level.
module lj_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [47:0] o_out_force_x,
    input logic signed [47:0] o_out_force_y,
    input logic signed [47:0] o_out_force_z,
    input logic signed [47:0] o_out_energy,
    input logic signed [47:0] o_out_virial,
    input logic               o_within_cutoff,
    input logic               o_overflow_flag
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_force_x) && $stable(o_out_energy)
            && $stable(o_out_virial) && $stable(o_overflow_flag))
        else $error("stalled result changed");

    // The clearing pass holds off input transactions right after reset.
    a_clear_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_in_stall)
        else $error("input accepted during memory clear");

    // A flag without an applied force only comes from a zero distance.
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow_flag && !o_within_cutoff |->
            o_out_force_x == 48'sd0 && o_out_force_y == 48'sd0 && o_out_force_z == 48'sd0
            && o_out_energy == 48'sd0 && o_out_virial == 48'sd0)
        else $error("zero distance result carries data");

endmodule

bind lennard_jones_pair_force_engine_top lj_chk u_lj_chk (.*);
